// ----- hdl/y4mh_pkg.sv -----
package y4mh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } hdr_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [1:0]  pixel_format;
        logic [31:0] rate_numerator;
        logic [31:0] rate_denominator;
        logic [8:0]  header_length;
    } res_req_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [15:0] width_acc;
        logic [15:0] height_acc;
        logic [31:0] num_acc;
        logic [31:0] den_acc;
        logic [1:0]  format_seen;
        logic [15:0] color_chars;
        logic [1:0]  error_flags;
    } parse_state_t;

    localparam logic [3:0] PH_MAGIC  = 4'd0;
    localparam logic [3:0] PH_SEP    = 4'd1;
    localparam logic [3:0] PH_SKIP   = 4'd2;
    localparam logic [3:0] PH_WIDTH  = 4'd3;
    localparam logic [3:0] PH_HEIGHT = 4'd4;
    localparam logic [3:0] PH_COL0   = 4'd5;
    localparam logic [3:0] PH_COL1   = 4'd6;
    localparam logic [3:0] PH_COL2   = 4'd7;
    localparam logic [3:0] PH_RNUM   = 4'd8;
    localparam logic [3:0] PH_RDEN   = 4'd9;
    localparam logic [3:0] PH_DRAIN  = 4'd10;
    localparam logic [3:0] PH_DONE   = 4'd11;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_COLOR     = 2'd2;

    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_420  = 2'd1;
    localparam logic [1:0] FMT_422  = 2'd2;
    localparam logic [1:0] FMT_444  = 2'd3;

    localparam logic [1:0] ERR_MALFORMED = 2'b01;
    localparam logic [1:0] ERR_COLOR     = 2'b10;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_FOUR    = 8'h34;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_W       = 8'h57;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_F       = 8'h46;

    localparam int          MAGIC_LEN        = 9;
    localparam logic [31:0] DEFAULT_RATE_NUM = 32'd30;
    localparam logic [31:0] DEFAULT_RATE_DEN = 32'd1;

    localparam parse_state_t STATE_RESET = '{
        phase:       PH_MAGIC,
        width_acc:   16'd0,
        height_acc:  16'd0,
        num_acc:     32'd0,
        den_acc:     32'd0,
        format_seen: FMT_NONE,
        color_chars: 16'd0,
        error_flags: 2'b00
    };

    function automatic logic [7:0] magic_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h59;
            4'd1:    c = 8'h55;
            4'd2:    c = 8'h56;
            4'd3:    c = 8'h34;
            4'd4:    c = 8'h4d;
            4'd5:    c = 8'h50;
            4'd6:    c = 8'h45;
            4'd7:    c = 8'h47;
            4'd8:    c = 8'h32;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/y4mh_step.sv -----
module y4mh_step
    import y4mh_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = 256,
    parameter int POS_W            = $clog2(MAX_HEADER_BYTES + 1)
)
(
    input  hdr_req_t           req,
    input  parse_state_t       st,
    input  logic [POS_W-1:0]   pos,
    output parse_state_t       st_next,
    output logic [POS_W-1:0]   pos_next,
    output res_req_t           res,
    output logic               res_valid
);

    localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_HEADER_BYTES);
    localparam logic [POS_W-1:0] MAGIC_POS = POS_W'(MAGIC_LEN);

    function automatic res_req_t make_result(input parse_state_t s,
                                             input logic [POS_W-1:0] p,
                                             input logic nl_seen);
        res_req_t r;
        r = '0;
        if (!nl_seen || s.error_flags[0]) begin
            r.status = ST_MALFORMED;
        end
        else if (s.error_flags[1]) begin
            r.status = ST_COLOR;
        end
        else if (s.width_acc == 16'd0 || s.height_acc == 16'd0) begin
            r.status = ST_MALFORMED;
        end
        else begin
            r.status        = ST_OK;
            r.frame_width   = s.width_acc;
            r.frame_height  = s.height_acc;
            r.pixel_format  = (s.format_seen == FMT_NONE) ? 2'd0 : s.format_seen - 2'd1;
            r.header_length = 9'(p);
            if (s.num_acc == 32'd0 || s.den_acc == 32'd0) begin
                r.rate_numerator   = DEFAULT_RATE_NUM;
                r.rate_denominator = DEFAULT_RATE_DEN;
            end
            else begin
                r.rate_numerator   = s.num_acc;
                r.rate_denominator = s.den_acc;
            end
        end
        return r;
    endfunction

    logic [7:0]  b;
    logic        nl;
    logic        is_digit;
    logic [3:0]  digit;
    logic [15:0] width_mac;
    logic [15:0] height_mac;
    logic [31:0] num_mac;
    logic [31:0] den_mac;
    logic [3:0]  after_token;
    logic [7:0]  c0;
    logic [7:0]  c1;

    assign b           = req.data_byte;
    assign nl          = (b == CH_NEWLINE);
    assign is_digit    = b inside {[CH_ZERO:CH_NINE]};
    assign digit       = b[3:0];
    assign after_token = (b == CH_SPACE) ? PH_SEP : PH_SKIP;
    assign c0          = st.color_chars[7:0];
    assign c1          = st.color_chars[15:8];

    // x * 10 as (x << 3) + (x << 1)
    assign width_mac  = (st.width_acc << 3) + (st.width_acc << 1) + 16'(digit);
    assign height_mac = (st.height_acc << 3) + (st.height_acc << 1) + 16'(digit);
    assign num_mac    = (st.num_acc << 3) + (st.num_acc << 1) + 32'(digit);
    assign den_mac    = (st.den_acc << 3) + (st.den_acc << 1) + 32'(digit);

    always_comb
    begin
        st_next   = st;
        pos_next  = pos;
        res       = '0;
        res_valid = 1'b0;
        if (st.phase == PH_DONE) begin
            if (req.buffer_end) begin
                st_next  = STATE_RESET;
                pos_next = '0;
            end
        end
        else begin
            // header too long
            if (pos >= MAX_POS) begin
                st_next.error_flags = st_next.error_flags | ERR_MALFORMED;
                st_next.phase       = PH_DRAIN;
            end
            else begin
                pos_next = pos + 1'b1;
            end

            case (st_next.phase)
                PH_MAGIC:
                begin
                    if (pos_next > MAGIC_POS ||
                        b != magic_char(pos_next[3:0] - 4'd1)) begin
                        st_next.error_flags = st_next.error_flags | ERR_MALFORMED;
                        st_next.phase       = PH_DRAIN;
                    end
                    else if (pos_next == MAGIC_POS) begin
                        st_next.phase = PH_SEP;
                    end
                end
                PH_SEP:
                begin
                    if (b == CH_SPACE) begin
                        st_next.phase = PH_SEP;
                    end
                    else if (b == CH_W) begin
                        st_next.width_acc = 16'd0;
                        st_next.phase     = PH_WIDTH;
                    end
                    else if (b == CH_H) begin
                        st_next.height_acc = 16'd0;
                        st_next.phase      = PH_HEIGHT;
                    end
                    else if (b == CH_C) begin
                        st_next.color_chars = 16'd0;
                        st_next.phase       = PH_COL0;
                    end
                    else if (b == CH_F) begin
                        st_next.num_acc = 32'd0;
                        st_next.den_acc = 32'd0;
                        st_next.phase   = PH_RNUM;
                    end
                    else begin
                        st_next.phase = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (b == CH_SPACE) begin
                        st_next.phase = PH_SEP;
                    end
                end
                PH_WIDTH:
                begin
                    if (is_digit) begin
                        st_next.width_acc = width_mac;
                    end
                    else begin
                        st_next.phase = after_token;
                    end
                end
                PH_HEIGHT:
                begin
                    if (is_digit) begin
                        st_next.height_acc = height_mac;
                    end
                    else begin
                        st_next.phase = after_token;
                    end
                end
                PH_COL0, PH_COL1:
                begin
                    if (b == CH_SPACE || nl) begin
                        st_next.error_flags = st_next.error_flags | ERR_COLOR;
                        st_next.phase       = PH_SEP;
                    end
                    else if (st_next.phase == PH_COL0) begin
                        st_next.color_chars = {8'd0, b};
                        st_next.phase       = PH_COL1;
                    end
                    else begin
                        st_next.color_chars = {b, st.color_chars[7:0]};
                        st_next.phase       = PH_COL2;
                    end
                end
                PH_COL2:
                begin
                    if (c0 == CH_FOUR && c1 == CH_TWO && b == CH_ZERO) begin
                        st_next.format_seen = FMT_420;
                    end
                    else if (c0 == CH_FOUR && c1 == CH_TWO && b == CH_TWO) begin
                        st_next.format_seen = FMT_422;
                    end
                    else if (c0 == CH_FOUR && c1 == CH_FOUR && b == CH_FOUR) begin
                        st_next.format_seen = FMT_444;
                    end
                    else begin
                        st_next.error_flags = st_next.error_flags | ERR_COLOR;
                    end
                    st_next.phase = after_token;
                end
                PH_RNUM:
                begin
                    if (is_digit) begin
                        st_next.num_acc = num_mac;
                    end
                    else if (b == CH_COLON) begin
                        st_next.phase = PH_RDEN;
                    end
                    else begin
                        st_next.phase = after_token;
                    end
                end
                PH_RDEN:
                begin
                    if (is_digit) begin
                        st_next.den_acc = den_mac;
                    end
                    else begin
                        st_next.phase = after_token;
                    end
                end
                default:
                begin
                    st_next.phase = st_next.phase;
                end
            endcase

            if (nl) begin
                res           = make_result(st_next, pos_next, 1'b1);
                res_valid     = 1'b1;
                st_next.phase = PH_DONE;
            end
            if (req.buffer_end) begin
                if (!nl) begin
                    res = make_result(st_next, pos_next, 1'b0);
                end
                res_valid = 1'b1;
                st_next   = STATE_RESET;
                pos_next  = '0;
            end
        end
    end

endmodule

// ----- hdl/y4m_stream_header_parser.sv -----
// Parses a YUV4MPEG2 stream header arriving one byte per request and reports
// status, frame size, pixel format, frame rate and header length once per
// header, at the newline or at buffer_end if no newline came. A byte is taken
// every cycle: the parse state and all accumulators update in the cycle the
// byte is accepted, and a result leaves from an output register backed by one
// skid entry, so the input stalls only while both of those hold results that
// the downstream side has not taken. Bytes after the newline are ignored until
// buffer_end, which rearms the parser.
module y4m_stream_header_parser
    import y4mh_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = 256
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     hdr_valid,
    output logic     hdr_stall,
    input  hdr_req_t hdr_data,
    output logic     res_valid,
    input  logic     res_stall,
    output res_req_t res_data
);

    localparam int POS_W = $clog2(MAX_HEADER_BYTES + 1);

    parse_state_t     st_reg;
    parse_state_t     st_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    res_req_t         step_res;
    logic             step_res_valid;

    logic     out_valid_reg;
    res_req_t out_data_reg;
    logic     skid_valid_reg;
    res_req_t skid_data_reg;

    logic hdr_accept;
    logic out_fire;
    logic produce;

    y4mh_step #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
        .POS_W            (POS_W)
    ) u_step (
        .req       (hdr_data),
        .st        (st_reg),
        .pos       (pos_reg),
        .st_next   (st_next),
        .pos_next  (pos_next),
        .res       (step_res),
        .res_valid (step_res_valid)
    );

    assign hdr_stall  = skid_valid_reg;
    assign hdr_accept = hdr_valid && !hdr_stall;
    assign out_fire   = out_valid_reg && !res_stall;
    assign produce    = hdr_accept && step_res_valid;
    assign res_valid  = out_valid_reg;
    assign res_data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg  <= STATE_RESET;
            pos_reg <= '0;
        end
        else if (hdr_accept) begin
            st_reg  <= st_next;
            pos_reg <= pos_next;
        end
    end

    // output register plus one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg) begin
            if (out_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_fire) begin
            out_valid_reg <= produce;
        end
        else if (produce) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || out_fire) begin
            if (produce) begin
                out_data_reg <= step_res;
            end
        end
        else if (produce) begin
            skid_data_reg <= step_res;
        end
    end

endmodule

// ----- tb/y4mh_checker.sv -----
module y4mh_checker
    import y4mh_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = 256
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     hdr_valid,
    input  logic     hdr_stall,
    input  hdr_req_t hdr_data,
    input  logic     res_valid,
    input  logic     res_stall,
    input  res_req_t res_data,
    input  logic     run_done,
    output int       fail_count,
    output int       pending
);

    localparam logic [71:0] MAGIC_TEXT = "YUV4MPEG2";

    logic [3:0]  phase;
    logic [12:0] byte_pos;
    logic [15:0] width_acc;
    logic [15:0] height_acc;
    logic [31:0] num_acc;
    logic [31:0] den_acc;
    logic [1:0]  format_seen;
    logic [15:0] color_chars;
    logic [1:0]  error_flags;

    res_req_t header_summaries_q[$];
    res_req_t want;
    int       mismatch_cnt;
    bit       done_seen;

    task automatic clear_parse();
        phase       = PH_MAGIC;
        byte_pos    = '0;
        width_acc   = '0;
        height_acc  = '0;
        num_acc     = '0;
        den_acc     = '0;
        format_seen = FMT_NONE;
        color_chars = '0;
        error_flags = '0;
    endtask

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [3:0] after_token(input logic [7:0] b);
        return (b == CH_SPACE) ? PH_SEP : PH_SKIP;
    endfunction

    function automatic res_req_t header_summary(input logic nl_seen);
        res_req_t s;
        s = '0;
        if (!nl_seen || (error_flags & ERR_MALFORMED) != 0)
            s.status = ST_MALFORMED;
        else if ((error_flags & ERR_COLOR) != 0)
            s.status = ST_COLOR;
        else if (width_acc == 0 || height_acc == 0)
            s.status = ST_MALFORMED;
        else
            s.status = ST_OK;
        if (s.status == ST_OK)
        begin
            s.frame_width   = width_acc;
            s.frame_height  = height_acc;
            s.pixel_format  = (format_seen == FMT_NONE) ? 2'd0 : format_seen - FMT_420;
            if (num_acc == 0 || den_acc == 0)
            begin
                s.rate_numerator   = DEFAULT_RATE_NUM;
                s.rate_denominator = DEFAULT_RATE_DEN;
            end
            else
            begin
                s.rate_numerator   = num_acc;
                s.rate_denominator = den_acc;
            end
            s.header_length = byte_pos[8:0];
        end
        return s;
    endfunction

    task automatic parse_header_byte(input hdr_req_t req);
        logic [7:0] b;
        logic       nl;
        logic       emitted;
        b       = req.data_byte;
        nl      = (b == CH_NEWLINE);
        emitted = 1'b0;
        if (phase == PH_DONE)
        begin
            if (req.buffer_end)
                clear_parse();
        end
        else
        begin
            if (byte_pos >= MAX_HEADER_BYTES)
            begin
                error_flags = error_flags | ERR_MALFORMED;
                phase       = PH_DRAIN;
            end
            else
                byte_pos = byte_pos + 13'd1;

            case (phase)
                PH_MAGIC:
                begin
                    if (byte_pos > MAGIC_LEN ||
                        b != MAGIC_TEXT[8*(MAGIC_LEN - int'(byte_pos)) +: 8])
                    begin
                        error_flags = error_flags | ERR_MALFORMED;
                        phase       = PH_DRAIN;
                    end
                    else if (byte_pos == MAGIC_LEN)
                        phase = PH_SEP;
                end
                PH_SEP:
                begin
                    if (b == CH_SPACE)
                        phase = PH_SEP;
                    else if (b == CH_W)
                    begin
                        width_acc = '0;
                        phase     = PH_WIDTH;
                    end
                    else if (b == CH_H)
                    begin
                        height_acc = '0;
                        phase      = PH_HEIGHT;
                    end
                    else if (b == CH_C)
                    begin
                        color_chars = '0;
                        phase       = PH_COL0;
                    end
                    else if (b == CH_F)
                    begin
                        num_acc = '0;
                        den_acc = '0;
                        phase   = PH_RNUM;
                    end
                    else
                        phase = PH_SKIP;
                end
                PH_SKIP:
                begin
                    if (b == CH_SPACE)
                        phase = PH_SEP;
                end
                PH_WIDTH:
                begin
                    if (is_digit(b))
                        width_acc = width_acc * 16'd10 + {8'd0, b - CH_ZERO};
                    else
                        phase = after_token(b);
                end
                PH_HEIGHT:
                begin
                    if (is_digit(b))
                        height_acc = height_acc * 16'd10 + {8'd0, b - CH_ZERO};
                    else
                        phase = after_token(b);
                end
                PH_COL0, PH_COL1:
                begin
                    if (b == CH_SPACE || nl)
                    begin
                        error_flags = error_flags | ERR_COLOR;
                        phase       = PH_SEP;
                    end
                    else if (phase == PH_COL0)
                    begin
                        color_chars = {8'd0, b};
                        phase       = PH_COL1;
                    end
                    else
                    begin
                        color_chars = color_chars | {b, 8'd0};
                        phase       = PH_COL2;
                    end
                end
                PH_COL2:
                begin
                    if (color_chars[7:0] == CH_FOUR && color_chars[15:8] == CH_TWO &&
                        b == CH_ZERO)
                        format_seen = FMT_420;
                    else if (color_chars[7:0] == CH_FOUR && color_chars[15:8] == CH_TWO &&
                             b == CH_TWO)
                        format_seen = FMT_422;
                    else if (color_chars[7:0] == CH_FOUR && color_chars[15:8] == CH_FOUR &&
                             b == CH_FOUR)
                        format_seen = FMT_444;
                    else
                        error_flags = error_flags | ERR_COLOR;
                    phase = after_token(b);
                end
                PH_RNUM:
                begin
                    if (is_digit(b))
                        num_acc = num_acc * 32'd10 + {24'd0, b - CH_ZERO};
                    else if (b == CH_COLON)
                        phase = PH_RDEN;
                    else
                        phase = after_token(b);
                end
                PH_RDEN:
                begin
                    if (is_digit(b))
                        den_acc = den_acc * 32'd10 + {24'd0, b - CH_ZERO};
                    else
                        phase = after_token(b);
                end
                default:
                begin
                end
            endcase

            if (nl)
            begin
                header_summaries_q.push_back(header_summary(1'b1));
                emitted = 1'b1;
                phase   = PH_DONE;
            end
            if (req.buffer_end)
            begin
                if (!emitted)
                    header_summaries_q.push_back(header_summary(1'b0));
                clear_parse();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            header_summaries_q.delete();
            mismatch_cnt = 0;
            done_seen    = 1'b0;
            fail_count   <= 0;
            pending      <= 0;
        end
        else
        begin
            // results leave from a register after their closing byte, so check them first
            if (res_valid && !res_stall)
            begin
                if (header_summaries_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: st=%0d w=%0d h=%0d fmt=%0d rate=%0d/%0d len=%0d",
                                 res_data.status, res_data.frame_width, res_data.frame_height,
                                 res_data.pixel_format, res_data.rate_numerator,
                                 res_data.rate_denominator, res_data.header_length);
                end
                else
                begin
                    want = header_summaries_q.pop_front();
                    if (res_data.status !== want.status ||
                        res_data.frame_width !== want.frame_width ||
                        res_data.frame_height !== want.frame_height ||
                        res_data.pixel_format !== want.pixel_format ||
                        res_data.rate_numerator !== want.rate_numerator ||
                        res_data.rate_denominator !== want.rate_denominator ||
                        res_data.header_length !== want.header_length)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                        begin
                            $display("mismatch exp: st=%0d w=%0d h=%0d fmt=%0d rate=%0d/%0d len=%0d",
                                     want.status, want.frame_width, want.frame_height,
                                     want.pixel_format, want.rate_numerator,
                                     want.rate_denominator, want.header_length);
                            $display("         got: st=%0d w=%0d h=%0d fmt=%0d rate=%0d/%0d len=%0d",
                                     res_data.status, res_data.frame_width,
                                     res_data.frame_height, res_data.pixel_format,
                                     res_data.rate_numerator, res_data.rate_denominator,
                                     res_data.header_length);
                        end
                    end
                end
            end

            if (hdr_valid && !hdr_stall)
                parse_header_byte(hdr_data);

            if (run_done && !done_seen)
            begin
                done_seen = 1'b1;
                if (header_summaries_q.size() != 0)
                begin
                    mismatch_cnt += header_summaries_q.size();
                    $display("%0d expected results never arrived", header_summaries_q.size());
                end
            end

            fail_count <= mismatch_cnt;
            pending    <= header_summaries_q.size();
        end
    end

endmodule

// ----- tb/tb_y4m_stream_header_parser.sv -----
module tb_y4m_stream_header_parser;
    import y4mh_pkg::*;

    localparam int MAX_HDR     = 256;
    localparam int BYTE_TARGET = 1650;
    localparam int MIN_HEADERS = 60;
    localparam int CYCLE_LIMIT = 1000000;

    localparam int TOK_W     = 0;
    localparam int TOK_H     = 1;
    localparam int TOK_C     = 2;
    localparam int TOK_F     = 3;
    localparam int TOK_OTHER = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        hdr_valid = 1'b0;
    logic        hdr_stall;
    hdr_req_t    hdr_data = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_req_t    res_data;
    logic        run_done = 1'b0;
    logic        sink_idle_en = 1'b0;
    int          fail_count;
    int          pending;
    int unsigned cycle_cnt = 0;
    int          stall_hold = 0;

    bit          src_idle_en;
    logic [7:0]  buf_q[$];
    int          trailing;
    int          bytes_sent;
    int          headers_sent;
    int          kind;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    y4m_stream_header_parser #(
        .MAX_HEADER_BYTES(MAX_HDR)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .hdr_data  (hdr_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    y4mh_checker #(
        .MAX_HEADER_BYTES(MAX_HDR)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .hdr_valid  (hdr_valid),
        .hdr_stall  (hdr_stall),
        .hdr_data   (hdr_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .run_done   (run_done),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // downstream back-pressure
    always @(posedge clk)
    begin
        if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else if (!sink_idle_en || $urandom_range(0, 2) != 0)
        begin
            res_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 8);
        end
        else
        begin
            res_stall  <= 1'b1;
            stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            buf_q.push_back(s[i]);
    endtask

    task automatic put_printable(input int n);
        repeat (n) buf_q.push_back(8'($urandom_range(33, 126)));
    endtask

    task automatic put_value(input string big);
        int r;
        int n;
        r = $urandom_range(0, 19);
        if (r == 0)
            put_text(big);
        else
        begin
            if (r == 1)
                n = 0;
            else if (r < 17)
                n = $urandom_range(1, 4);
            else
                n = $urandom_range(5, 12);
            repeat (n) buf_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic put_token(input int tok);
        int r;
        r = $urandom_range(0, 99);
        case (tok)
            TOK_W:
            begin
                buf_q.push_back(CH_W);
                put_value(r[0] ? "65535" : "65536");
            end
            TOK_H:
            begin
                buf_q.push_back(CH_H);
                put_value(r[0] ? "65535" : "65536");
            end
            TOK_C:
            begin
                buf_q.push_back(CH_C);
                if (r < 75)
                begin
                    case (r % 3)
                        0:       put_text("420");
                        1:       put_text("422");
                        default: put_text("444");
                    endcase
                end
                else if (r < 88)
                    repeat (3) buf_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                else if (r < 94)
                    put_text("42");
                else if (r < 97)
                    put_text("4");
            end
            TOK_F:
            begin
                buf_q.push_back(CH_F);
                put_value(r[0] ? "4294967295" : "4294967296");
                if ($urandom_range(0, 9) != 0)
                begin
                    buf_q.push_back(CH_COLON);
                    put_value(r[1] ? "4294967295" : "4294967296");
                end
            end
            default:
                put_printable($urandom_range(1, 6));
        endcase
        // junk after the value
        if ($urandom_range(0, 6) == 0)
            put_printable($urandom_range(1, 4));
    endtask

    task automatic build_header(input bit good_magic);
        int idx;
        int ntok;
        int tok;
        bit swap_wh;
        put_text("YUV4MPEG2");
        if (!good_magic)
        begin
            idx = $urandom_range(0, 8);
            if ($urandom_range(0, 1))
                buf_q[idx] = 8'($urandom_range(0, 255));
            else
                while (buf_q.size() > idx) buf_q.delete(buf_q.size() - 1);
        end
        ntok    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 7);
        swap_wh = $urandom_range(0, 1);
        for (int i = 0; i < ntok; i++)
        begin
            if (i < 2 && $urandom_range(0, 9) != 0)
                tok = swap_wh ? 1 - i : i;
            else
                tok = $urandom_range(TOK_W, TOK_OTHER);
            if ($urandom_range(0, 11) != 0)
                repeat (($urandom_range(0, 3) == 0) ? 2 : 1) buf_q.push_back(CH_SPACE);
            put_token(tok);
        end
        if ($urandom_range(0, 11) != 0)
        begin
            buf_q.push_back(CH_NEWLINE);
            trailing = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 4);
            repeat (trailing) buf_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_buffer();
        hdr_req_t req;
        int       gap;
        int       r;
        for (int i = 0; i < buf_q.size(); i++)
        begin
            req.data_byte  = buf_q[i];
            req.buffer_end = (i == buf_q.size() - 1);
            gap = 0;
            if (src_idle_en)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    gap = 0;
                else if (r < 90)
                    gap = $urandom_range(1, 3);
                else if (r < 98)
                    gap = $urandom_range(4, 10);
                else
                    gap = $urandom_range(20, 60);
            end
            if (gap > 0)
            begin
                hdr_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            hdr_valid <= 1'b1;
            hdr_data  <= req;
            @(posedge clk);
            while (hdr_stall) @(posedge clk);
        end
        bytes_sent   += buf_q.size() - trailing;
        headers_sent += 1;
        buf_q.delete();
        trailing = 0;
    endtask

    initial
    begin
        trailing     = 0;
        bytes_sent   = 0;
        headers_sent = 0;
        src_idle_en  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // newline while still matching the magic
        put_text("\n");
        send_buffer();
        // buffer ends with no newline
        put_text("YUV4MPEG");
        send_buffer();
        // no size tags at all
        put_text("YUV4MPEG2\n");
        send_buffer();
        buf_q.push_back(8'hff);
        buf_q.push_back(8'h00);
        send_buffer();

        while (bytes_sent < BYTE_TARGET || headers_sent < MIN_HEADERS)
        begin
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en <= ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 72)
                build_header(1'b1);
            else if (kind < 80)
                build_header(1'b0);
            else if (kind < 92)
            begin
                repeat (($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 16))
                    buf_q.push_back(($urandom_range(0, 9) == 0) ? CH_NEWLINE
                                                               : 8'($urandom_range(0, 255)));
            end
            else if (kind < 95)
            begin
                // header ending near the size limit, on either side of it
                put_text("YUV4MPEG2 W");
                put_value("65535");
                put_text(" H");
                put_value("65535");
                put_text(" X");
                put_printable($urandom_range(250, 262) - 1 - buf_q.size());
                if ($urandom_range(0, 9) != 0)
                    buf_q.push_back(CH_NEWLINE);
            end
            else
            begin
                // burst of one-byte buffers
                repeat ($urandom_range(3, 11))
                begin
                    buf_q.push_back($urandom_range(0, 1) ? CH_NEWLINE
                                                         : 8'($urandom_range(0, 255)));
                    send_buffer();
                end
                buf_q.push_back(CH_NEWLINE);
            end
            send_buffer();
        end
        hdr_valid <= 1'b0;

        // let the checker count the last request before reading pending
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
